@@ rtl/nsc_pkg.sv @@
// ----------------------------------------------------------------------------
// nsc_pkg: shared types and constants
// Character codes, status codes, register indexes and the result word type
// used by the sentence checker.
// ----------------------------------------------------------------------------
`default_nettype none

package nsc_pkg;

    // Character codes
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;

    // Result status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_HEADER = 3'd1;
    localparam logic [2:0] ST_BAD_TOKENS = 3'd2;
    localparam logic [2:0] ST_BAD_CSUM   = 3'd3;
    localparam logic [2:0] ST_OVERFLOW   = 3'd4;

    // Configuration register indexes
    localparam logic [0:0] REG_HEADER_ID  = 1'b0;
    localparam logic [0:0] REG_EXP_TOKENS = 1'b1;

    // Register reset values ("GPRMC", eleven tokens)
    localparam logic [39:0] HEADER_ID_RESET  = 40'h4750524D43;
    localparam logic [3:0]  EXP_TOKENS_RESET = 4'd11;

    localparam logic [3:0] TOKEN_MAX = 4'd15;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] checksum;
        logic [8:0] length;
    } result_t;

    // Output buffer occupancy, used by the input side for flow control
    typedef struct packed {
        logic out_busy;
        logic skid_busy;
    } buf_status_t;

    // Hex digit decode in either case: {is_hex, value}
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
            r = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66)
            r = {1'b1, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46)
            r = {1'b1, 4'(c - 8'h37)};
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/nmea_sentence_checker.sv @@
// ----------------------------------------------------------------------------
// nmea_sentence_checker: NMEA 0183 sentence checker
// Hunts for '$', collects a sentence and reports header, token count and
// checksum status, or overflow, once per sentence.
// ----------------------------------------------------------------------------
// Feed received characters one word per cycle on rx_byte; the block sustains
// one word per clock while in_ready is high. Each word is registered; in the
// next cycle the sentence state is updated and, at CR LF or when MAX_LEN bytes
// have been collected, a result word is written into a two-entry output
// buffer, so out_valid rises at the clock edge after the one that accepts the
// word ending the sentence. in_ready drops only while results back up in that
// buffer (consumer holding out_ready low). Bytes before a '$' produce nothing.
// The checksum field is the XOR of collected bytes before the first '*'; the
// two characters ahead of CR are read as hex in either case. Status priority:
// wrong header, then wrong token count, then bad checksum. header_id and
// expected_tokens are written through the cfg port (always ready); the user
// must write them only while the block is idle; the block does not check it.
// ----------------------------------------------------------------------------
`default_nettype none

module nmea_sentence_checker
    import nsc_pkg::*;
#(
    parameter int MAX_LEN = 256
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // received characters
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_byte,
    // results
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       status,
    output logic [7:0]       computed_checksum,
    output logic [8:0]       sentence_length,
    // configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [39:0] cfg_data
);

    logic [39:0] header_id_reg;
    logic [3:0]  exp_tokens_reg;

    logic        stage_valid_reg, stage_valid_next;
    logic [7:0]  stage_byte_reg;
    logic        in_accept;

    logic        res_valid;
    result_t     res;
    result_t     out_res;
    buf_status_t buf_stat;

    // config registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_id_reg  <= HEADER_ID_RESET;
            exp_tokens_reg <= EXP_TOKENS_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_HEADER_ID:  header_id_reg  <= cfg_data;
                REG_EXP_TOKENS: exp_tokens_reg <= cfg_data[3:0];
                default:        ;
            endcase
        end
    end

    // Accept only if the word in the stage plus this one can both land in
    // the buffer: the skid entry must be empty and, with the stage full, the output
    // register must be empty or draining this cycle.
    assign in_ready  = !buf_stat.skid_busy
                       && !(stage_valid_reg && buf_stat.out_busy && !out_ready);
    assign in_accept = in_valid && in_ready;
    assign stage_valid_next = in_accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else
            stage_valid_reg <= stage_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            stage_byte_reg <= rx_byte;
    end

    nsc_core #(
        .MAX_LEN (MAX_LEN)
    ) u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .byte_valid      (stage_valid_reg),
        .rx_byte         (stage_byte_reg),
        .header_id       (header_id_reg),
        .expected_tokens (exp_tokens_reg),
        .res_valid       (res_valid),
        .res             (res)
    );

    nsc_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_res  (res),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_res   (out_res),
        .stat      (buf_stat)
    );

    assign status            = out_res.status;
    assign computed_checksum = out_res.checksum;
    assign sentence_length   = out_res.length;

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status <= ST_OVERFLOW))
        else $error("status code out of range");

endmodule

`default_nettype wire

@@ rtl/nsc_core.sv @@
// ----------------------------------------------------------------------------
// nsc_core: sentence state and per-word decision
// Holds the hunt/collect state, running XOR, header match, token count and
// the last three bytes; decides end, overflow and status for each word.
// ----------------------------------------------------------------------------
`default_nettype none

module nsc_core
    import nsc_pkg::*;
#(
    parameter int MAX_LEN = 256
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          byte_valid,
    input  wire logic [7:0]    rx_byte,
    input  wire logic [39:0]   header_id,
    input  wire logic [3:0]    expected_tokens,
    output logic               res_valid,
    output result_t            res
);

    localparam int IDX_W = $clog2(MAX_LEN + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_LEN - 1);
    localparam logic [8:0]       OVF_LEN  = 9'(MAX_LEN % 512);

    logic             collecting_reg, collecting_next;
    logic [IDX_W-1:0] index_reg,      index_next;
    logic [7:0]       xor_reg,        xor_next;
    logic             star_reg,       star_next;
    logic             hdr_ok_reg,     hdr_ok_next;
    logic [3:0]       tokens_reg,     tokens_next;
    logic             in_token_reg,   in_token_next;
    logic [7:0]       recent0_reg,    recent0_next;
    logic [7:0]       recent1_reg,    recent1_next;
    logic [7:0]       recent2_reg,    recent2_next;

    logic [7:0] hdr_char;
    logic       in_header;
    logic       is_end;
    logic       hm_end;
    logic [3:0] tok_end;
    logic [4:0] hex_hi;
    logic [4:0] hex_lo;

    // Expected header character at the current index (valid while index < 5)
    always_comb
    begin
        case (index_reg[2:0])
            3'd0:    hdr_char = header_id[39:32];
            3'd1:    hdr_char = header_id[31:24];
            3'd2:    hdr_char = header_id[23:16];
            3'd3:    hdr_char = header_id[15:8];
            default: hdr_char = header_id[7:0];
        endcase
    end

    assign in_header = (index_reg < IDX_W'(5));
    assign is_end    = collecting_reg && (index_reg > IDX_W'(2))
                       && (recent0_reg == CHAR_CR) && (rx_byte == CHAR_LF);

    // End-of-sentence checks; LF still counts as a header byte at index 4
    assign hm_end  = hdr_ok_reg && !(in_header && rx_byte != hdr_char)
                     && !(index_reg < IDX_W'(4));
    assign tok_end = (recent1_reg != CHAR_COMMA && tokens_reg != TOKEN_MAX)
                     ? tokens_reg + 4'd1 : tokens_reg;
    assign hex_hi  = hex_decode(recent2_reg);
    assign hex_lo  = hex_decode(recent1_reg);

    always_comb
    begin
        collecting_next = collecting_reg;
        index_next      = index_reg;
        xor_next        = xor_reg;
        star_next       = star_reg;
        hdr_ok_next     = hdr_ok_reg;
        tokens_next     = tokens_reg;
        in_token_next   = in_token_reg;
        recent0_next    = recent0_reg;
        recent1_next    = recent1_reg;
        recent2_next    = recent2_reg;
        res_valid       = 1'b0;
        res.status      = ST_OK;
        res.checksum    = xor_reg;
        res.length      = 9'(index_reg) + 9'd1;

        if (byte_valid)
        begin
            if (!collecting_reg)
            begin
                if (rx_byte == CHAR_DOLLAR)
                begin
                    collecting_next = 1'b1;
                    index_next      = '0;
                    xor_next        = 8'd0;
                    star_next       = 1'b0;
                    hdr_ok_next     = 1'b1;
                    tokens_next     = 4'd0;
                    in_token_next   = 1'b0;
                    recent0_next    = 8'd0;
                    recent1_next    = 8'd0;
                    recent2_next    = 8'd0;
                end
            end
            else if (is_end)
            begin
                collecting_next = 1'b0;
                res_valid       = 1'b1;
                if (!hm_end)
                    res.status = ST_BAD_HEADER;
                else if (tok_end != expected_tokens)
                    res.status = ST_BAD_TOKENS;
                else if (!hex_hi[4] || !hex_lo[4]
                         || {hex_hi[3:0], hex_lo[3:0]} != xor_reg)
                    res.status = ST_BAD_CSUM;
                else
                    res.status = ST_OK;
            end
            else
            begin
                if (in_header && rx_byte != hdr_char)
                    hdr_ok_next = 1'b0;
                if (!star_reg)
                begin
                    if (rx_byte == CHAR_STAR)
                        star_next = 1'b1;
                    else
                        xor_next = xor_reg ^ rx_byte;
                end
                if (rx_byte == CHAR_COMMA)
                begin
                    if (in_token_reg && tokens_reg != TOKEN_MAX)
                        tokens_next = tokens_reg + 4'd1;
                    in_token_next = 1'b0;
                end
                else
                begin
                    in_token_next = 1'b1;
                end
                recent2_next = recent1_reg;
                recent1_next = recent0_reg;
                recent0_next = rx_byte;
                index_next   = index_reg + IDX_W'(1);

                // buffer full without an end
                if (index_reg == LAST_IDX)
                begin
                    collecting_next = 1'b0;
                    res_valid       = 1'b1;
                    res.status      = ST_OVERFLOW;
                    res.checksum    = xor_next;
                    res.length      = OVF_LEN;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            collecting_reg <= 1'b0;
            index_reg      <= '0;
            xor_reg        <= 8'd0;
            star_reg       <= 1'b0;
            hdr_ok_reg     <= 1'b1;
            tokens_reg     <= 4'd0;
            in_token_reg   <= 1'b0;
            recent0_reg    <= 8'd0;
            recent1_reg    <= 8'd0;
            recent2_reg    <= 8'd0;
        end
        else
        begin
            collecting_reg <= collecting_next;
            index_reg      <= index_next;
            xor_reg        <= xor_next;
            star_reg       <= star_next;
            hdr_ok_reg     <= hdr_ok_next;
            tokens_reg     <= tokens_next;
            in_token_reg   <= in_token_next;
            recent0_reg    <= recent0_next;
            recent1_reg    <= recent1_next;
            recent2_reg    <= recent2_next;
        end
    end

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        collecting_reg |-> index_reg <= LAST_IDX)
        else $error("byte index past last slot");

    a_result_only_collecting: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> collecting_reg && !collecting_next)
        else $error("result without an open sentence");

    a_overflow_at_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.status == ST_OVERFLOW) |-> index_reg == LAST_IDX)
        else $error("overflow before buffer full");

endmodule

`default_nettype wire

@@ rtl/nsc_out_buf.sv @@
// ----------------------------------------------------------------------------
// nsc_out_buf: two-entry result buffer
// Output register plus skid entry so the input side keeps running while a
// result waits for the consumer.
// ----------------------------------------------------------------------------
`default_nettype none

module nsc_out_buf
    import nsc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire result_t  push_res,
    input  wire logic     out_ready,
    output logic          out_valid,
    output result_t       out_res,
    output buf_status_t   stat
);

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_reg, out_next;
    result_t skid_reg, skid_next;
    logic    pop;

    assign pop = out_valid_reg && out_ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_next        = skid_reg;
                skid_valid_next = push;
                skid_next       = push_res;
            end
            else
            begin
                out_valid_next = push;
                out_next       = push_res;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_next       = push_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid      = out_valid_reg;
    assign out_res        = out_reg;
    assign stat.out_busy  = out_valid_reg;
    assign stat.skid_busy = skid_valid_reg;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with empty output register");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && skid_valid_reg && !pop))
        else $error("result pushed into full buffer");

endmodule

`default_nettype wire

@@ verif/nmea_sentence_checker_test.sv @@
// ----------------------------------------------------------------------------
// nmea_sentence_checker_test: self-checking testbench for the sentence checker
// Streams received characters into the block with random gaps, drains results
// with a stall pattern of its own and checks every result word against a
// sentence tracker kept in step with each accepted character. A directed part
// covers the status cases, short and overflowing sentences and odd bytes;
// random traffic then runs under several register settings.
// ----------------------------------------------------------------------------
`default_nettype none

module nmea_sentence_checker_test;
    import nsc_pkg::*;

    localparam int SENTENCE_MAX    = 256;
    localparam int TAIL_CYCLES     = 8;       // margin past the result delay
    localparam int WATCHDOG_CYCLES = 400000;

    // What follows the fields of a generated sentence
    typedef enum int {
        TAIL_UPPER,     // '*' and checksum in uppercase hex
        TAIL_LOWER,     // '*' and checksum in lowercase hex
        TAIL_WRONG,     // '*' and a checksum that does not match
        TAIL_NONHEX,    // '*' with one non-hex digit
        TAIL_NOSTAR,    // hex digits with no '*' ahead of them
        TAIL_NONE       // nothing, straight to CR LF
    } tail_kind_t;

    // Receiver stall styles
    typedef enum int {
        DRAIN_OPEN,     // always ready
        DRAIN_COIN,     // ready half the time
        DRAIN_TRICKLE,  // ready with probability one in eight
        DRAIN_PULSE     // ready while bit 2 of the phase counter is set
    } drain_style_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  rx_byte = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  status;
    logic [7:0]  computed_checksum;
    logic [8:0]  sentence_length;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [0:0]  cfg_index = REG_HEADER_ID;
    logic [39:0] cfg_data = 40'd0;

    nmea_sentence_checker #(.MAX_LEN(SENTENCE_MAX)) u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .rx_byte           (rx_byte),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .status            (status),
        .computed_checksum (computed_checksum),
        .sentence_length   (sentence_length),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Sentence tracker: registers, per-sentence state and expected results
    // ------------------------------------------------------------------------
    logic [39:0] cfg_header;
    logic [3:0]  cfg_tokens;

    logic        in_sentence;       // 0 while hunting for '$'
    int          char_pos;          // bytes taken since '$'
    logic [7:0]  xor_acc;
    logic        star_hit;
    logic        header_ok;
    int          field_tokens;      // saturates at TOKEN_MAX
    logic        mid_token;
    logic [7:0]  last3 [0:2];       // [0] newest

    result_t     sentence_reports_due [$];
    int          reports_predicted = 0;
    int          sentence_bytes = 0;    // words taken while collecting
    int          mismatches = 0;

    // Stimulus helpers
    logic [7:0]  line_buf [$];
    int          burst_left = 0;
    logic        gapless = 1'b0;

    task automatic clear_sentence_state();
        char_pos     = 0;
        xor_acc      = 8'h00;
        star_hit     = 1'b0;
        header_ok    = 1'b1;
        field_tokens = 0;
        mid_token    = 1'b0;
        last3[0]     = 8'h00;
        last3[1]     = 8'h00;
        last3[2]     = 8'h00;
    endtask

    task automatic reset_tracker();
        cfg_header  = HEADER_ID_RESET;
        cfg_tokens  = EXP_TOKENS_RESET;
        in_sentence = 1'b0;
        clear_sentence_state();
    endtask

    // Expected header character at a sentence position; positions past the
    // fifth all map onto the last one.
    function automatic logic [7:0] header_char(input int pos);
        int p;
        p = (pos > 4) ? 4 : pos;
        return cfg_header[8 * (4 - p) +: 8];
    endfunction

    function automatic int hex_value(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39)
            return int'(c) - 48;
        if (c >= 8'h61 && c <= 8'h66)
            return int'(c) - 87;
        if (c >= 8'h41 && c <= 8'h46)
            return int'(c) - 55;
        return -1;
    endfunction

    // Advance the tracker by one accepted word; queue a result if it ends
    // or overflows a sentence.
    task automatic track_sentence_byte(input logic [7:0] b);
        int      k;
        int      tokens;
        int      hi;
        int      lo;
        logic    hm;
        result_t r;
        k = char_pos;
        if (!in_sentence)
        begin
            if (b == CHAR_DOLLAR)
            begin
                in_sentence = 1'b1;
                clear_sentence_state();
            end
            return;
        end
        sentence_bytes++;

        // CR LF with the LF at position 3 or later closes the sentence
        if (k > 2 && last3[0] == CHAR_CR && b == CHAR_LF)
        begin
            hm = header_ok;
            if (k < 5 && b != header_char(k))
                hm = 1'b0;
            if (k < 4)
                hm = 1'b0;      // fifth header character never arrived
            tokens = field_tokens + ((last3[1] != CHAR_COMMA) ? 1 : 0);
            if (tokens > int'(TOKEN_MAX))
                tokens = int'(TOKEN_MAX);
            hi = hex_value(last3[2]);
            lo = hex_value(last3[1]);
            if (!hm)
                r.status = ST_BAD_HEADER;
            else if (tokens != int'(cfg_tokens))
                r.status = ST_BAD_TOKENS;
            else if (hi < 0 || lo < 0 || (hi * 16 + lo) != int'(xor_acc))
                r.status = ST_BAD_CSUM;
            else
                r.status = ST_OK;
            r.checksum = xor_acc;
            r.length   = 9'(k + 1);
            sentence_reports_due.push_back(r);
            reports_predicted++;
            in_sentence = 1'b0;
            return;
        end

        if (k < 5 && b != header_char(k))
            header_ok = 1'b0;
        if (!star_hit)
        begin
            if (b == CHAR_STAR)
                star_hit = 1'b1;
            else
                xor_acc ^= b;
        end
        if (b == CHAR_COMMA)
        begin
            if (mid_token && field_tokens < int'(TOKEN_MAX))
                field_tokens++;
            mid_token = 1'b0;
        end
        else
            mid_token = 1'b1;
        last3[2] = last3[1];
        last3[1] = last3[0];
        last3[0] = b;
        char_pos = k + 1;

        if (char_pos >= SENTENCE_MAX)
        begin
            r.status   = ST_OVERFLOW;
            r.checksum = xor_acc;
            r.length   = 9'(SENTENCE_MAX);
            sentence_reports_due.push_back(r);
            reports_predicted++;
            in_sentence = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------------
    // Result checker: every accepted result word against the oldest
    // expectation, field by field.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (sentence_reports_due.size() == 0)
            begin
                $display("%0t: unexpected result status %0d checksum %02h length %0d",
                         $time, status, computed_checksum, sentence_length);
                mismatches++;
            end
            else
            begin
                want = sentence_reports_due.pop_front();
                if (status !== want.status)
                begin
                    $display("%0t: status expected %0d, got %0d",
                             $time, want.status, status);
                    mismatches++;
                end
                if (computed_checksum !== want.checksum)
                begin
                    $display("%0t: computed_checksum expected %02h, got %02h",
                             $time, want.checksum, computed_checksum);
                    mismatches++;
                end
                if (sentence_length !== want.length)
                begin
                    $display("%0t: sentence_length expected %0d, got %0d",
                             $time, want.length, sentence_length);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: switches among stall styles at random, so open stretches
    // alternate with back-pressure that fills the output buffer.
    // ------------------------------------------------------------------------
    drain_style_t drain_style = DRAIN_OPEN;
    int           drain_left = 0;
    int           drain_phase = 0;

    always @(posedge clk)
    begin
        if (drain_left == 0)
        begin
            drain_style = drain_style_t'($urandom_range(0, 3));
            drain_left  = $urandom_range(20, 200);
        end
        drain_left--;
        drain_phase++;
        case (drain_style)
            DRAIN_OPEN:    out_ready <= 1'b1;
            DRAIN_COIN:    out_ready <= ($urandom_range(0, 1) == 1);
            DRAIN_TRICKLE: out_ready <= ($urandom_range(0, 7) == 0);
            default:       out_ready <= ((drain_phase & 4) != 0);
        endcase
    end

    // Watchdog
    int cycle_count = 0;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > WATCHDOG_CYCLES)
        begin
            $display("nmea_sentence_checker regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------

    // One character word. Bursts of random length are separated by random
    // gaps unless the current phase runs gapless.
    task automatic send_word(input logic [7:0] b);
        int gap;
        if (!gapless && burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap        = $urandom_range(0, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        if (burst_left > 0)
            burst_left--;
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        track_sentence_byte(b);
    endtask

    task automatic send_line();
        int i;
        for (i = 0; i < line_buf.size(); i++)
            send_word(line_buf[i]);
    endtask

    task automatic start_line();
        line_buf.delete();
        line_buf.push_back(CHAR_DOLLAR);
    endtask

    task automatic push_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endtask

    task automatic push_line_end();
        line_buf.push_back(CHAR_CR);
        line_buf.push_back(CHAR_LF);
    endtask

    // Field content: mostly printable, now and then any byte; never a
    // separator, a star or a line end.
    function automatic logic [7:0] field_char();
        logic [7:0] c;
        do
        begin
            if ($urandom_range(0, 19) == 0)
                c = 8'($urandom_range(0, 255));
            else
                c = 8'($urandom_range(32, 126));
        end
        while (c == CHAR_STAR || c == CHAR_COMMA || c == CHAR_CR || c == CHAR_LF);
        return c;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v, input logic lower);
        if (v < 4'd10)
            return 8'h30 + 8'(v);
        return (lower ? 8'h57 : 8'h37) + 8'(v);
    endfunction

    function automatic logic [39:0] letters_header();
        logic [39:0] h;
        int          i;
        for (i = 0; i < 5; i++)
            h[8 * i +: 8] = 8'($urandom_range(65, 90));
        return h;
    endfunction

    // '$', five header characters and nfields comma-led fields. Some empty
    // fields are slipped in mid-line, where they add no token.
    task automatic build_body(input logic [39:0] hdr, input int nfields);
        int i;
        int j;
        int flen;
        start_line();
        for (i = 4; i >= 0; i--)
            line_buf.push_back(hdr[8 * i +: 8]);
        for (i = 0; i < nfields; i++)
        begin
            line_buf.push_back(CHAR_COMMA);
            if (i < nfields - 1 && $urandom_range(0, 7) == 0)
                line_buf.push_back(CHAR_COMMA);
            flen = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 2);
            for (j = 0; j < flen; j++)
                line_buf.push_back(field_char());
        end
    endtask

    // Append the checksum tail and CR LF, then send the whole line.
    task automatic seal_sentence(input tail_kind_t kind);
        logic [7:0] sum;
        logic [7:0] v;
        logic [7:0] junk;
        int         i;
        sum = 8'h00;
        for (i = 1; i < line_buf.size(); i++)
        begin
            if (line_buf[i] == CHAR_STAR)
                break;
            sum ^= line_buf[i];
        end
        v    = sum;
        junk = 8'($urandom_range(71, 90));     // 'G'..'Z'
        case (kind)
            TAIL_UPPER, TAIL_LOWER, TAIL_WRONG:
            begin
                if (kind == TAIL_WRONG)
                    v = sum ^ 8'($urandom_range(1, 255));
                line_buf.push_back(CHAR_STAR);
                line_buf.push_back(hex_char(v[7:4], kind == TAIL_LOWER));
                line_buf.push_back(hex_char(v[3:0], kind == TAIL_LOWER));
            end
            TAIL_NONHEX:
            begin
                line_buf.push_back(CHAR_STAR);
                if ($urandom_range(0, 1) == 1)
                begin
                    line_buf.push_back(junk);
                    line_buf.push_back(hex_char(v[3:0], 1'b0));
                end
                else
                begin
                    line_buf.push_back(hex_char(v[7:4], 1'b0));
                    line_buf.push_back(junk);
                end
            end
            TAIL_NOSTAR:
            begin
                line_buf.push_back(hex_char(v[7:4], 1'b0));
                line_buf.push_back(hex_char(v[3:0], 1'b0));
            end
            default: ;
        endcase
        push_line_end();
        send_line();
    endtask

    // Pause the sender until every queued result has drained, plus a
    // TAIL_CYCLES margin.
    task automatic hold_until_reported();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sentence_reports_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // Bring the block back to hunting and fully idle before a register write.
    task automatic settle();
        while (in_sentence)
        begin
            if (char_pos < 2)
                send_word(8'h58);
            else if (last3[0] != CHAR_CR)
                send_word(CHAR_CR);
            else
                send_word(CHAR_LF);
        end
        hold_until_reported();
    endtask

    // Writes both registers back to back; valid stays up between them.
    task automatic set_config(input logic [39:0] hdr, input logic [3:0] tokens);
        cfg_valid <= 1'b1;
        cfg_index <= REG_HEADER_ID;
        cfg_data  <= hdr;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_header = hdr;
        cfg_index <= REG_EXP_TOKENS;
        cfg_data  <= {36'd0, tokens};
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_tokens = tokens;
        cfg_valid <= 1'b0;
    endtask

    // A sentence shaped for the current registers, with a random tail.
    task automatic random_sentence(input logic truncate);
        logic [39:0] hdr;
        int          n;
        int          pick;
        hdr  = ($urandom_range(0, 99) < 85) ? cfg_header : letters_header();
        n    = ($urandom_range(0, 99) < 80) ? int'(cfg_tokens) - 1 : $urandom_range(0, 18);
        build_body(hdr, n);
        if (truncate)
        begin
            // Broken sentence: the next '$' lands inside it as plain data
            n = $urandom_range(1, line_buf.size() - 1);
            while (line_buf.size() > n)
                void'(line_buf.pop_back());
            send_line();
            return;
        end
        pick = $urandom_range(0, 99);
        if (pick < 65)
            seal_sentence(TAIL_UPPER);
        else if (pick < 80)
            seal_sentence(TAIL_LOWER);
        else if (pick < 87)
            seal_sentence(TAIL_WRONG);
        else if (pick < 93)
            seal_sentence(TAIL_NONHEX);
        else if (pick < 97)
            seal_sentence(TAIL_NOSTAR);
        else
            seal_sentence(TAIL_NONE);
    endtask

    task automatic overflow_run(input int fill);
        int i;
        start_line();
        for (i = 0; i < fill; i++)
            line_buf.push_back(8'($urandom_range(48, 122)));
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset registers: noise while hunting, then a good sentence
    task automatic test_default_sentences();
        send_word(8'h00);
        send_word(8'hFF);
        send_word(CHAR_CR);
        send_word(CHAR_LF);
        send_word(CHAR_STAR);
        send_word(CHAR_COMMA);
        build_body(cfg_header, 10);
        seal_sentence(TAIL_UPPER);
    endtask

    // A good lowercase sentence, each failing status alone, then pairs to
    // check the priority order
    task automatic test_status_priority();
        int n;
        n = int'(cfg_tokens) - 1;
        build_body(cfg_header, n);
        seal_sentence(TAIL_LOWER);
        build_body(40'h4750474741, n);      // GPGGA
        seal_sentence(TAIL_UPPER);
        build_body(cfg_header, n - 1);
        seal_sentence(TAIL_UPPER);
        build_body(cfg_header, n + 1);
        seal_sentence(TAIL_UPPER);
        build_body(cfg_header, n);
        seal_sentence(TAIL_WRONG);
        build_body(cfg_header, n);
        seal_sentence(TAIL_NONHEX);
        build_body(cfg_header, n);
        seal_sentence(TAIL_NOSTAR);
        build_body(40'h4750474741, n + 2);  // header beats token count
        seal_sentence(TAIL_WRONG);
        build_body(cfg_header, n + 2);      // token count beats checksum
        seal_sentence(TAIL_WRONG);
    endtask

    // Line ends at positions 2, 3 and 4 after '$'
    task automatic test_short_sentences();
        start_line();
        push_text("GP");
        push_line_end();
        send_line();
        start_line();
        push_text("GPR");
        push_line_end();
        send_line();
        // LF at position 2 does not end; the next CR LF does
        start_line();
        push_text("G");
        push_line_end();
        push_line_end();
        send_line();
    endtask

    // Stray dollars, comma layouts and unusual bytes in fields
    task automatic test_dollars_and_commas();
        int n;
        n = int'(cfg_tokens) - 1;
        build_body(cfg_header, n);
        line_buf[line_buf.size() - 1] = CHAR_DOLLAR;
        seal_sentence(TAIL_UPPER);
        build_body(cfg_header, n);
        line_buf.insert(1, CHAR_DOLLAR);
        seal_sentence(TAIL_UPPER);
        build_body(cfg_header, n);
        line_buf.insert(1, CHAR_COMMA);
        seal_sentence(TAIL_UPPER);
        build_body(cfg_header, n);
        line_buf.insert(7, CHAR_COMMA);
        seal_sentence(TAIL_UPPER);
        build_body(cfg_header, n);
        line_buf.push_back(CHAR_COMMA);
        seal_sentence(TAIL_NONE);
        build_body(cfg_header, n);
        line_buf.push_back(CHAR_COMMA);
        seal_sentence(TAIL_UPPER);
        // last field holds NUL, a lone CR, a lone LF and 0xFF
        build_body(cfg_header, n - 1);
        line_buf.push_back(CHAR_COMMA);
        line_buf.push_back(8'h00);
        line_buf.push_back(CHAR_CR);
        line_buf.push_back(8'h41);
        line_buf.push_back(CHAR_LF);
        line_buf.push_back(8'hFF);
        seal_sentence(TAIL_UPPER);
    endtask

    // More than fifteen tokens read as fifteen
    task automatic test_token_saturation();
        build_body(cfg_header, 18);
        seal_sentence(TAIL_UPPER);
    endtask

    // CR on the last slot is no end, so the sentence overflows there
    task automatic test_overflow();
        overflow_run(SENTENCE_MAX - 1);
        push_line_end();
        send_line();
    endtask

    // Header whose last two characters are CR LF: a line end at position 4
    // matches the whole header.
    task automatic test_line_end_header();
        start_line();
        push_text("GPR");
        push_line_end();
        send_line();
        start_line();
        push_text("GP");
        push_line_end();
        send_line();
        random_sentence(1'b0);
    endtask

    // Mostly well-formed sentences; the rest noise, broken lines, short
    // lines and drains.
    task automatic test_random_traffic(input int byte_goal, input int report_goal);
        int b0;
        int r0;
        int pick;
        int n;
        b0      = sentence_bytes;
        r0      = reports_predicted;
        gapless = ($urandom_range(0, 3) == 0);
        while (sentence_bytes - b0 < byte_goal || reports_predicted - r0 < report_goal)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 72)
                random_sentence(1'b0);
            else if (pick < 83)
            begin
                n = $urandom_range(1, 8);
                repeat (n) send_word(8'($urandom_range(0, 255)));
            end
            else if (pick < 91)
                random_sentence(1'b1);
            else if (pick < 94)
                hold_until_reported();
            else
            begin
                start_line();
                n = $urandom_range(1, 4);
                repeat (n) line_buf.push_back(8'($urandom_range(0, 255)));
                push_line_end();
                send_line();
            end
        end
        gapless = 1'b0;
    endtask

    initial
    begin
        reset_tracker();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_default_sentences();

        // Short sentences for the directed part
        settle();
        set_config(HEADER_ID_RESET, 4'd3);
        test_status_priority();
        test_short_sentences();
        test_dollars_and_commas();
        test_overflow();
        test_random_traffic(20, 2);

        // Register extremes
        settle();
        set_config(40'h0000000000, 4'd1);
        test_random_traffic(20, 2);
        settle();
        set_config(40'hFFFFFFFFFF, TOKEN_MAX);
        test_token_saturation();

        settle();
        set_config(40'h4750520D0A, 4'd1);
        test_line_end_header();

        // Random settings, then back to the reset values by a write
        settle();
        set_config(letters_header(), 4'($urandom_range(1, 15)));
        test_random_traffic(10, 1);
        settle();
        set_config(HEADER_ID_RESET, EXP_TOKENS_RESET);
        test_random_traffic(10, 1);

        hold_until_reported();
        if (mismatches == 0)
            $display("nmea_sentence_checker regression: pass");
        else
            $display("nmea_sentence_checker regression: fail");
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/nsc_pkg.sv
rtl/nsc_core.sv
rtl/nsc_out_buf.sv
rtl/nmea_sentence_checker.sv
verif/nmea_sentence_checker_test.sv
